@@ rtl/core/bmmp_pkg.sv @@
// bmmp_pkg: shared types and constants for the binomial mod matrix power block
// no dependencies
package bmmp_pkg;

    localparam int unsigned WORD_W = 31;
    localparam int unsigned R_W    = 4;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [R_W-1:0]    t_rsel;

    localparam t_word RESET_MODULUS = t_word'(1000000007);

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INIT,
        CELL_LOAD,
        CELL_SHIFT_A,
        CELL_BIT,
        CELL_ACCUM,
        CELL_WB_ACC,
        CELL_WB_BASE
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     a_bit;
        logic     sel_acc;
        t_word    one_val;
        t_word    modulus;
    } t_cell_ctrl;

endpackage

@@ rtl/core/bmmp_if.sv @@
// bmmp_in_if / bmmp_out_if: valid/ready channels of the block
// depends on bmmp_pkg
interface bmmp_in_if;
    logic                 valid;
    logic                 ready;
    bmmp_pkg::t_word      n_value;
    bmmp_pkg::t_rsel      r_index;
    modport source (output valid, output n_value, output r_index, input ready);
    modport sink   (input valid, input n_value, input r_index, output ready);
endinterface

interface bmmp_out_if;
    logic                 valid;
    logic                 ready;
    bmmp_pkg::t_word      binomial_value;
    modport source (output valid, output binomial_value, input ready);
    modport sink   (input valid, input binomial_value, output ready);
endinterface

@@ rtl/core/bmmp_cell.sv @@
// bmmp_cell: one coefficient cell of the polynomial multiply chain
// bit-serial modular multiply plus modular accumulate; depends on bmmp_pkg
module bmmp_cell #(
    parameter int unsigned INDEX = 0
) (
    input  logic                 i_clk,
    input  bmmp_pkg::t_cell_ctrl i_ctrl,
    input  bmmp_pkg::t_word      i_as,
    input  bmmp_pkg::t_word      i_bs,
    output bmmp_pkg::t_word      o_as,
    output bmmp_pkg::t_word      o_bs,
    output bmmp_pkg::t_word      o_acc
);
    import bmmp_pkg::*;

    t_word r_acc, r_base, r_as, r_bs, r_p, r_c;
    logic [WORD_W+1:0] w_t, w_m1, w_m2;
    logic [WORD_W:0]   w_s;
    t_word             w_p_next, w_c_next;

    always_comb begin
        w_m1 = {2'b00, i_ctrl.modulus};
        w_m2 = {1'b0, i_ctrl.modulus, 1'b0};
        w_t  = {1'b0, r_p, 1'b0} + (i_ctrl.a_bit ? {2'b00, r_bs} : '0);
        if (w_t >= w_m2) begin
            w_p_next = t_word'(w_t - w_m2);
        end else if (w_t >= w_m1) begin
            w_p_next = t_word'(w_t - w_m1);
        end else begin
            w_p_next = t_word'(w_t);
        end
        w_s = {1'b0, r_c} + {1'b0, r_p};
        if (w_s >= {1'b0, i_ctrl.modulus}) begin
            w_c_next = t_word'(w_s - {1'b0, i_ctrl.modulus});
        end else begin
            w_c_next = t_word'(w_s);
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            CELL_INIT: begin
                r_acc  <= (INDEX == 0) ? i_ctrl.one_val : '0;
                r_base <= (INDEX <= 1) ? i_ctrl.one_val : '0;
            end
            CELL_LOAD: begin
                r_as <= i_ctrl.sel_acc ? r_acc : r_base;
                r_bs <= r_base;
                r_c  <= '0;
            end
            CELL_SHIFT_A: begin
                r_as <= i_as;
                r_p  <= '0;
            end
            CELL_BIT: begin
                r_p <= w_p_next;
            end
            CELL_ACCUM: begin
                r_c  <= w_c_next;
                r_bs <= i_bs;
            end
            CELL_WB_ACC: begin
                r_acc <= r_c;
            end
            CELL_WB_BASE: begin
                r_base <= r_c;
            end
            default: begin
            end
        endcase
    end

    assign o_as  = r_as;
    assign o_bs  = r_bs;
    assign o_acc = r_acc;

endmodule

@@ rtl/core/binomial_mod_matrix_power_top.sv @@
// binomial_mod_matrix_power_top: C(n,r) mod m by square-and-multiply
// depends on bmmp_pkg, bmmp_if, bmmp_cell
//
// channel | dir | payload                 | handshake
// i_in    | in  | n_value, r_index        | valid/ready
// o_out   | out | binomial_value          | valid/ready
// cfg     | in  | modulus (i_cfg_wr_data) | i_cfg_wr_en
//
// one item at a time; each polynomial multiply runs on the cell chain
// (31 bit-serial steps per coefficient), about 2*log2(n) of them per item
// reset is synchronous; modulus returns to 1000000007
// a finished result waits in the output register; the next item is taken
// meanwhile but its result is held until the output register frees
module binomial_mod_matrix_power_top #(
    parameter int unsigned R_MAX = 15
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  bmmp_pkg::t_word   i_cfg_wr_data,
    bmmp_in_if.sink           i_in,
    bmmp_out_if.source        o_out
);
    import bmmp_pkg::*;

    localparam int unsigned DIM   = R_MAX + 1;
    localparam int unsigned IW    = $clog2(DIM);
    localparam int unsigned BIT_W = $clog2(WORD_W);

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_DECIDE, S_AFTER, S_LOAD, S_GETA, S_BITS, S_ACCUM, S_WB,
        S_DONE
    } t_state;

    t_state           r_state;
    t_word            r_mod, r_m, r_n, r_a, r_out_data;
    logic [IW-1:0]    r_idx, r_j;
    logic [BIT_W-1:0] r_bit;
    logic             r_zero, r_sq, r_out_valid;

    t_cell_ctrl w_ctrl;
    t_word      w_as  [DIM];
    t_word      w_bs  [DIM];
    t_word      w_acc [DIM];

    always_comb begin
        w_ctrl.modulus = r_m;
        w_ctrl.one_val = (r_m == t_word'(1)) ? '0 : t_word'(1);
        w_ctrl.a_bit   = r_a[WORD_W-1];
        w_ctrl.sel_acc = !r_sq;
        case (r_state)
            S_INIT:  w_ctrl.op = CELL_INIT;
            S_LOAD:  w_ctrl.op = CELL_LOAD;
            S_GETA:  w_ctrl.op = CELL_SHIFT_A;
            S_BITS:  w_ctrl.op = CELL_BIT;
            S_ACCUM: w_ctrl.op = CELL_ACCUM;
            S_WB:    w_ctrl.op = r_sq ? CELL_WB_BASE : CELL_WB_ACC;
            default: w_ctrl.op = CELL_HOLD;
        endcase
    end

    for (genvar k = 0; k < DIM; k++) begin : g_cell
        t_word w_as_in, w_bs_in;
        if (k == DIM - 1) begin : g_last
            assign w_as_in = '0;
        end else begin : g_mid
            assign w_as_in = w_as[k+1];
        end
        if (k == 0) begin : g_first
            assign w_bs_in = '0;
        end else begin : g_rest
            assign w_bs_in = w_bs[k-1];
        end
        bmmp_cell #(.INDEX(k)) u_cell (
            .i_clk  (i_clk),
            .i_ctrl (w_ctrl),
            .i_as   (w_as_in),
            .i_bs   (w_bs_in),
            .o_as   (w_as[k]),
            .o_bs   (w_bs[k]),
            .o_acc  (w_acc[k])
        );
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.binomial_value = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mod       <= RESET_MODULUS;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mod <= i_cfg_wr_data;
            end
            if (r_state == S_DONE && (!r_out_valid || o_out.ready)) begin
                r_out_valid <= 1'b1;
                r_out_data  <= r_zero ? '0 : w_acc[r_idx];
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_n    <= i_in.n_value;
                        r_idx  <= IW'(i_in.r_index);
                        r_zero <= (32'(i_in.r_index) > R_MAX);
                        r_m    <= (r_mod == '0) ? t_word'(1) : r_mod;
                        r_state <= (32'(i_in.r_index) > R_MAX) ? S_DONE : S_INIT;
                    end
                end
                S_INIT: begin
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (r_n == '0) begin
                        r_state <= S_DONE;
                    end else if (r_n[0]) begin
                        r_sq    <= 1'b0;
                        r_state <= S_LOAD;
                    end else begin
                        r_state <= S_AFTER;
                    end
                end
                S_AFTER: begin
                    r_n <= r_n >> 1;
                    if (r_n[WORD_W-1:1] != '0) begin
                        r_sq    <= 1'b1;
                        r_state <= S_LOAD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_LOAD: begin
                    r_j     <= '0;
                    r_state <= S_GETA;
                end
                S_GETA: begin
                    r_a     <= w_as[0];
                    r_bit   <= '0;
                    r_state <= S_BITS;
                end
                S_BITS: begin
                    r_a   <= r_a << 1;
                    r_bit <= r_bit + 1'b1;
                    if (r_bit == BIT_W'(WORD_W - 1)) begin
                        r_state <= S_ACCUM;
                    end
                end
                S_ACCUM: begin
                    if (r_j == r_idx) begin
                        r_state <= S_WB;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_GETA;
                    end
                end
                S_WB: begin
                    r_state <= r_sq ? S_DECIDE : S_AFTER;
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/core/bmmp_checker.sv @@
// bmmp_checker: port-level checks on binomial_mod_matrix_power_top
// bound to the top level below; depends on bmmp_pkg
module bmmp_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            i_in_ready,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input bmmp_pkg::t_word i_out_data
);
    logic [1:0] r_pend;
    logic       w_in_acc, w_out_acc;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + {1'b0, w_in_acc} - {1'b0, w_out_acc};
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped while stalled");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data))
        else $error("output data changed while stalled");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc |-> r_pend != 2'd0)
        else $error("output transaction without input transaction");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |-> r_pend < 2'd2)
        else $error("more than two transactions in flight");

endmodule

bind binomial_mod_matrix_power_top bmmp_checker u_bmmp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.binomial_value)
);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// testbench: checks binomial_mod_matrix_power_top, C(n,r) mod m, against a matrix-power predictor
// depends on bmmp_pkg, bmmp_if and the top level of the block
module testbench;
    import bmmp_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 200000;
    localparam int unsigned DRAIN_CYCLES   = 100;
    localparam int unsigned MAX_R          = 15;

    class binomial_scoreboard;
        t_word binomial_q[$];
        int    mismatches;

        function automatic t_word binomial_power(t_word n_in, t_rsel r_in, t_word m_in);
            longint unsigned base_m[MAX_R+1][MAX_R+1];
            longint unsigned acc_m[MAX_R+1][MAX_R+1];
            longint unsigned m;
            longint unsigned n;
            int sz;
            m  = (m_in == '0) ? 64'd1 : 64'(m_in);
            n  = 64'(n_in);
            sz = int'(r_in) + 1;
            for (int i = 0; i <= MAX_R; i++) begin
                for (int j = 0; j <= MAX_R; j++) begin
                    base_m[i][j] = 0;
                    acc_m[i][j]  = 0;
                end
            end
            for (int i = 0; i < sz; i++) begin
                base_m[i][i] = 64'd1 % m;
                acc_m[i][i]  = 64'd1 % m;
                if (i > 0) base_m[i][i-1] = 64'd1 % m;
            end
            while (n != 0) begin
                if (n[0]) acc_m = mat_mul_mod(acc_m, base_m, sz, m);
                n = n >> 1;
                if (n != 0) base_m = mat_mul_mod(base_m, base_m, sz, m);
            end
            return t_word'(acc_m[r_in][0]);
        endfunction

        typedef longint unsigned t_mat[MAX_R+1][MAX_R+1];

        function automatic t_mat mat_mul_mod(t_mat a, t_mat b, int sz, longint unsigned m);
            t_mat prod;
            longint unsigned s;
            prod = a;
            for (int i = 0; i < sz; i++) begin
                for (int j = 0; j < sz; j++) begin
                    s = 0;
                    for (int k = 0; k < sz; k++) s = (s + (a[i][k] * b[k][j]) % m) % m;
                    prod[i][j] = s;
                end
            end
            return prod;
        endfunction

        function void note_input(t_word n_in, t_rsel r_in, t_word m_in);
            binomial_q.push_back(binomial_power(n_in, r_in, m_in));
        endfunction

        task report(string msg);
            mismatches++;
            $display("mismatch: %s", msg);
        endtask

        task check_result(t_word value);
            t_word want;
            if (binomial_q.size() == 0) begin
                report($sformatf("unexpected result %0d", value));
                return;
            end
            want = binomial_q.pop_front();
            if (value !== want)
                report($sformatf("binomial_value got %0d want %0d", value, want));
        endtask
    endclass

    logic  i_clk;
    logic  i_rst_n;
    logic  i_cfg_wr_en;
    t_word i_cfg_wr_data;
    t_word cur_modulus;
    logic  hold_off;
    int    idle_cycles;

    bmmp_in_if  in_ch();
    bmmp_out_if out_ch();

    binomial_scoreboard sb = new();

    binomial_mod_matrix_power_top #(.R_MAX(MAX_R)) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (in_ch.sink),
        .o_out         (out_ch.source)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic int rand_gap();
        int p;
        p = $urandom_range(99);
        if (p < 65) return 0;
        if (p < 93) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    // result side
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.binomial_value);
    end

    initial begin
        int g;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off) begin
                out_ch.ready <= 1'b0;
                @(posedge i_clk);
            end else begin
                g = rand_gap();
                if (g == 0) begin
                    out_ch.ready <= 1'b1;
                    repeat ($urandom_range(40, 1)) @(posedge i_clk);
                end else begin
                    out_ch.ready <= 1'b0;
                    repeat (g) @(posedge i_clk);
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_item(t_word n_in, t_rsel r_in, int gap);
        in_ch.valid   <= 1'b1;
        in_ch.n_value <= n_in;
        in_ch.r_index <= r_in;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_input(n_in, r_in, cur_modulus);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_modulus(t_word value);
        while (sb.binomial_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        cur_modulus = value;
    endtask

    task automatic random_items(int count);
        t_word n;
        t_rsel r;
        int    p;
        for (int k = 0; k < count; k++) begin
            p = $urandom_range(99);
            r = t_rsel'($urandom_range(15));
            if (p < 50) n = t_word'($urandom_range(40));
            else if (p < 85) n = t_word'($urandom_range(70000));
            else begin
                n = t_word'($urandom());
                r = t_rsel'($urandom_range(4));
            end
            send_item(n, r, (k == count - 1) ? 1 : rand_gap());
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        in_ch.valid   <= 1'b0;
        in_ch.n_value <= '0;
        in_ch.r_index <= '0;
        hold_off      = 1'b0;
        idle_cycles   = 0;
        cur_modulus   = RESET_MODULUS;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, zero exponent, r above n
        send_item(t_word'(0), t_rsel'(0), 0);
        send_item(t_word'(0), t_rsel'(5), 2);
        send_item(t_word'(3), t_rsel'(7), 0);
        send_item(t_word'(1), t_rsel'(0), 0);
        send_item(t_word'(1), t_rsel'(1), 1);
        send_item(t_word'(15), t_rsel'(15), 0);
        send_item(t_word'(16), t_rsel'(15), 0);
        send_item(t_word'(30), t_rsel'(15), 3);
        send_item(t_word'(2147483647), t_rsel'(0), 0);
        send_item(t_word'(2147483647), t_rsel'(1), 0);
        send_item(t_word'(2147483647), t_rsel'(15), 1);
        send_item(t_word'(1431655765), t_rsel'(2), 1);
        send_item(t_word'(1000000007), t_rsel'(3), 1);
        write_modulus(t_word'(1));
        send_item(t_word'(0), t_rsel'(0), 0);
        send_item(t_word'(1), t_rsel'(1), 0);
        send_item(t_word'(20), t_rsel'(4), 1);
        write_modulus(t_word'(0));
        send_item(t_word'(0), t_rsel'(0), 0);
        send_item(t_word'(9), t_rsel'(3), 1);
        write_modulus(t_word'(2147483647));
        send_item(t_word'(2147483646), t_rsel'(2), 0);
        send_item(t_word'(60), t_rsel'(15), 0);
        send_item(t_word'(1 << 30), t_rsel'(1), 1);
        write_modulus(t_word'(2));
        send_item(t_word'(10), t_rsel'(5), 0);
        send_item(t_word'(13), t_rsel'(6), 1);

        // long output stall while small items keep coming
        write_modulus(t_word'(97));
        fork
            begin
                hold_off = 1'b1;
                repeat (4000) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int k = 0; k < 6; k++) send_item(t_word'($urandom_range(8)), t_rsel'($urandom_range(2)), (k == 5) ? 1 : 0);
        join

        random_items(25);
        write_modulus(t_word'($urandom_range(2147483647, 2)));
        random_items(25);
        write_modulus(t_word'(1000000007));
        random_items(25);

        while (sb.binomial_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
